// File: hw/rtl/rsf_pkg.sv
// shared types, constants and rate table for the rate servo and trigger fire control
package rsf_pkg;

    typedef enum logic [1:0] {
        OP_LOOP    = 2'd0,
        OP_CMD     = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    localparam int CFG_POS_BITS = 24;
    localparam int CFG_BITS     = 24;
    localparam int CFG_IDX_BITS = 3;
    localparam int RATE_BITS    = 15;

    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_POSITION  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_POSITION  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_DUTY   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_OFF_COUNT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAG_ON_TIME   = 3'd4;

    localparam logic signed [CFG_POS_BITS-1:0] MAX_POSITION_RST = 24'sd520000;
    localparam logic signed [CFG_POS_BITS-1:0] MIN_POSITION_RST = -24'sd640000;
    localparam logic [15:0] CENTER_DUTY_RST   = 16'd6542;
    localparam logic [3:0]  MIN_OFF_COUNT_RST = 4'd3;
    localparam logic [7:0]  MAG_ON_TIME_RST   = 8'd150;

    localparam logic [7:0]  STICK_CENTER = 8'd128;
    localparam logic [15:0] SHOT_FAULTED = 16'd65535;

    typedef struct packed {
        logic signed [CFG_POS_BITS-1:0] max_position;
        logic signed [CFG_POS_BITS-1:0] min_position;
        logic [15:0]                    center_duty;
        logic [3:0]                     min_off_count;
        logic [7:0]                     mag_on_time;
    } cfg_t;

    typedef struct packed {
        logic        fire_drive;
        logic        mag_drive;
        logic [15:0] shot_report;
        logic        fault;
        logic        trigger_accepted;
    } fire_status_t;

    // elevation rate per stick step away from center, entry 0 unused
    localparam logic [RATE_BITS-1:0] RATE_ROM [0:128] = '{
        15'd10, 15'd11, 15'd12, 15'd13, 15'd15, 15'd16, 15'd18, 15'd19,
        15'd21, 15'd24, 15'd26, 15'd29, 15'd31, 15'd35, 15'd38, 15'd42,
        15'd46, 15'd51, 15'd56, 15'd61, 15'd67, 15'd74, 15'd81, 15'd90,
        15'd98, 15'd108, 15'd119, 15'd131, 15'd144, 15'd159, 15'd174, 15'd192,
        15'd211, 15'd267, 15'd323, 15'd379, 15'd435, 15'd491, 15'd546, 15'd602,
        15'd658, 15'd714, 15'd770, 15'd826, 15'd882, 15'd938, 15'd994, 15'd1050,
        15'd1106, 15'd1161, 15'd1217, 15'd1273, 15'd1329, 15'd1385, 15'd1441, 15'd1497,
        15'd1553, 15'd1609, 15'd1665, 15'd1720, 15'd1776, 15'd1832, 15'd1888, 15'd1944,
        15'd2000, 15'd2312, 15'd2625, 15'd2938, 15'd3250, 15'd3562, 15'd3875, 15'd4188,
        15'd4500, 15'd4812, 15'd5125, 15'd5438, 15'd5750, 15'd6062, 15'd6375, 15'd6688,
        15'd7000, 15'd7312, 15'd7625, 15'd7938, 15'd8250, 15'd8562, 15'd8875, 15'd9188,
        15'd9500, 15'd9812, 15'd10125, 15'd10438, 15'd10750, 15'd11062, 15'd11375, 15'd11688,
        15'd12000, 15'd12312, 15'd12625, 15'd12938, 15'd13250, 15'd13562, 15'd13875, 15'd14188,
        15'd14500, 15'd14812, 15'd15125, 15'd15438, 15'd15750, 15'd16062, 15'd16375, 15'd16688,
        15'd17000, 15'd17312, 15'd17625, 15'd17938, 15'd18250, 15'd18562, 15'd18875, 15'd19188,
        15'd19500, 15'd19812, 15'd20125, 15'd20438, 15'd20750, 15'd21062, 15'd21375, 15'd21688,
        15'd21688
    };

endpackage

// File: hw/rtl/rate_servo_and_trigger_fire_control.sv
// top level of the elevation servo and fire actuator controller
//
// Each input word is one event (loop pass, command, fire timeout or switch
// release, chosen by s_tuser) and yields exactly one output word. A command
// steps the signed elevation position by a rate from a 129-entry table
// (subtracted above stick center, added below) and clamps it against the
// limit registers; the servo duty is center_duty plus the position shifted
// right by 8, saturated to 16 bits. Trigger presses qualify only after
// min_off_count trigger-off commands in a row, a qualified press starts
// firing and the timeout timer unless already firing or faulted, a timeout
// while the timer runs latches a sticky fault, and a switch release while
// firing counts a shot and arms the magazine countdown. Words pass an input
// register and then a result register, which drives m. One word per cycle
// is sustained while results are taken, since table lookup, add, clamp and
// duty saturation all sit in the single stage between the two registers.
// Both registers advance whenever the result register is empty or being
// drained. Configuration writes are meant for an idle block.
module rate_servo_and_trigger_fire_control
    import rsf_pkg::*;
#(
    parameter int POSITION_BITS = 24
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // input words
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [15:0]             s_tdata,   // stick_elevation[7:0], trigger_pressed, mag_inhibit
    input  logic [1:0]              s_tuser,   // op
    // result words
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [39:0]             m_tdata,   // elevation_duty[15:0], fire_drive, mag_drive,
                                               // shot_report[15:0], fault, trigger_accepted
    // configuration
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data
);

    cfg_t         cfg_reg;
    logic         in_valid_reg;
    op_t          op_reg;
    logic [7:0]   stick_reg;
    logic         trigger_reg;
    logic         inhibit_reg;
    logic         out_valid_reg;
    logic [15:0]  out_duty_reg;
    fire_status_t out_status_reg;
    logic         advance;
    logic         step;
    logic [15:0]  duty;
    fire_status_t status;

    // result register frees up when empty or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_position  <= MAX_POSITION_RST;
            cfg_reg.min_position  <= MIN_POSITION_RST;
            cfg_reg.center_duty   <= CENTER_DUTY_RST;
            cfg_reg.min_off_count <= MIN_OFF_COUNT_RST;
            cfg_reg.mag_on_time   <= MAG_ON_TIME_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_POSITION:  cfg_reg.max_position  <= $signed(cfg_data[CFG_POS_BITS-1:0]);
                REG_MIN_POSITION:  cfg_reg.min_position  <= $signed(cfg_data[CFG_POS_BITS-1:0]);
                REG_CENTER_DUTY:   cfg_reg.center_duty   <= cfg_data[15:0];
                REG_MIN_OFF_COUNT: cfg_reg.min_off_count <= cfg_data[3:0];
                REG_MAG_ON_TIME:   cfg_reg.mag_on_time   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg      <= op_t'(s_tuser);
            stick_reg   <= s_tdata[7:0];
            trigger_reg <= s_tdata[8];
            inhibit_reg <= s_tdata[9];
        end
    end

    rsf_servo #(
        .POSITION_BITS (POSITION_BITS)
    ) u_servo (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .op    (op_reg),
        .stick (stick_reg),
        .cfg   (cfg_reg),
        .duty  (duty)
    );

    rsf_fire u_fire (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .op              (op_reg),
        .trigger_pressed (trigger_reg),
        .mag_inhibit     (inhibit_reg),
        .cfg             (cfg_reg),
        .status          (status)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_duty_reg   <= duty;
            out_status_reg <= status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000,
                       out_status_reg.trigger_accepted,
                       out_status_reg.fault,
                       out_status_reg.shot_report,
                       out_status_reg.mag_drive,
                       out_status_reg.fire_drive,
                       out_duty_reg};

    // a faulted word always reports the fault shot code
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_status_reg.fault) |-> (out_status_reg.shot_report == SHOT_FAULTED))
        else $error("faulted word without fault shot code");

    // a qualified press leaves the actuator firing or the block faulted
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_status_reg.trigger_accepted)
            |-> (out_status_reg.fire_drive || out_status_reg.fault))
        else $error("accepted trigger without firing or fault");

    // firing never starts or continues under a fault
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_status_reg.fire_drive && out_status_reg.fault))
        else $error("fire drive active while faulted");

    // a held input word is not dropped while the result side stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input word lost during stall");

endmodule

// File: hw/rtl/rsf_servo.sv
// elevation position accumulator with clamp and servo duty computation
module rsf_servo
    import rsf_pkg::*;
#(
    parameter int POSITION_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  op_t         op,
    input  logic [7:0]  stick,
    input  cfg_t        cfg,
    output logic [15:0] duty
);

    localparam int CW = ((POSITION_BITS > CFG_POS_BITS) ? POSITION_BITS : CFG_POS_BITS) + 2;
    localparam int SW = POSITION_BITS - 8;
    localparam int DW = ((SW > 16) ? SW : 16) + 2;
    localparam logic signed [DW-1:0] DUTY_MAX = DW'(65535);

    logic signed [POSITION_BITS-1:0] position_reg;
    logic signed [POSITION_BITS-1:0] position_next;
    logic [7:0]                      rom_index;
    logic [RATE_BITS-1:0]            rate;
    logic signed [CW-1:0]            pos_ext;
    logic signed [CW-1:0]            rate_ext;
    logic signed [CW-1:0]            max_ext;
    logic signed [CW-1:0]            min_ext;
    logic signed [CW-1:0]            sum;
    logic signed [SW-1:0]            shifted;
    logic signed [DW-1:0]            duty_sum;

    always_comb
    begin
        // distance from center: stick above center uses its low bits
        rom_index = stick[7] ? {1'b0, stick[6:0]} : (STICK_CENTER - stick);
        rate      = RATE_ROM[rom_index];
        pos_ext   = CW'(position_reg);
        rate_ext  = $signed(CW'(rate));
        max_ext   = CW'(cfg.max_position);
        min_ext   = CW'(cfg.min_position);
        sum       = pos_ext;
        if (stick > STICK_CENTER)
        begin
            sum = pos_ext - rate_ext;
            if (sum < min_ext)
            begin
                sum = min_ext;
            end
        end
        else if (stick < STICK_CENTER)
        begin
            sum = pos_ext + rate_ext;
            if (sum > max_ext)
            begin
                sum = max_ext;
            end
        end
        position_next = position_reg;
        if (step && (op == OP_CMD))
        begin
            position_next = sum[POSITION_BITS-1:0];
        end
    end

    // floor shift by 8, then add center and saturate
    always_comb
    begin
        shifted  = position_next[POSITION_BITS-1:8];
        duty_sum = DW'(shifted) + $signed(DW'(cfg.center_duty));
        if (duty_sum < 0)
        begin
            duty = 16'd0;
        end
        else if (duty_sum > DUTY_MAX)
        begin
            duty = 16'hFFFF;
        end
        else
        begin
            duty = duty_sum[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
        end
        else
        begin
            position_reg <= position_next;
        end
    end

endmodule

// File: hw/rtl/rsf_fire.sv
// trigger qualification, fire cycle, fault, shot count and magazine countdown
module rsf_fire
    import rsf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  op_t          op,
    input  logic         trigger_pressed,
    input  logic         mag_inhibit,
    input  cfg_t         cfg,
    output fire_status_t status
);

    logic [3:0]  off_count_reg, off_count_next;
    logic        firing_reg, firing_next;
    logic        timer_reg, timer_next;
    logic        fault_reg, fault_next;
    logic [15:0] shot_reg, shot_next;
    logic [7:0]  mag_remaining_reg, mag_remaining_next;
    logic        last_inhibit_reg, last_inhibit_next;
    logic        mag_pin_reg, mag_pin_next;
    logic        accepted;

    always_comb
    begin
        off_count_next     = off_count_reg;
        firing_next        = firing_reg;
        timer_next         = timer_reg;
        fault_next         = fault_reg;
        shot_next          = shot_reg;
        mag_remaining_next = mag_remaining_reg;
        last_inhibit_next  = last_inhibit_reg;
        mag_pin_next       = mag_pin_reg;
        accepted           = 1'b0;
        if (step)
        begin
            case (op)
                OP_CMD:
                begin
                    if (trigger_pressed)
                    begin
                        accepted       = (off_count_reg >= cfg.min_off_count);
                        off_count_next = '0;
                    end
                    else if (off_count_reg >= cfg.min_off_count)
                    begin
                        off_count_next = cfg.min_off_count;
                    end
                    else
                    begin
                        off_count_next = off_count_reg + 4'd1;
                    end
                    last_inhibit_next = mag_inhibit;
                    if (accepted && !firing_reg && !fault_reg)
                    begin
                        firing_next = 1'b1;
                        timer_next  = 1'b1;
                    end
                end
                OP_TIMEOUT:
                begin
                    if (timer_reg)
                    begin
                        timer_next         = 1'b0;
                        firing_next        = 1'b0;
                        fault_next         = 1'b1;
                        mag_remaining_next = '0;
                    end
                end
                OP_RELEASE:
                begin
                    timer_next = 1'b0;
                    if (firing_reg)
                    begin
                        firing_next        = 1'b0;
                        shot_next          = shot_reg + 16'd1;
                        mag_remaining_next = cfg.mag_on_time;
                    end
                end
                default:
                begin
                end
            endcase
            // loop and command passes run the magazine countdown
            if ((op == OP_LOOP) || (op == OP_CMD))
            begin
                if (mag_remaining_reg != 8'd0)
                begin
                    mag_remaining_next = mag_remaining_reg - 8'd1;
                    mag_pin_next       = !last_inhibit_next;
                end
                else
                begin
                    mag_pin_next = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        status.fire_drive       = firing_next;
        status.mag_drive        = mag_pin_next;
        status.shot_report      = fault_next ? SHOT_FAULTED : shot_next;
        status.fault            = fault_next;
        status.trigger_accepted = accepted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_count_reg     <= '0;
            firing_reg        <= 1'b0;
            timer_reg         <= 1'b0;
            fault_reg         <= 1'b0;
            shot_reg          <= '0;
            mag_remaining_reg <= '0;
            last_inhibit_reg  <= 1'b0;
            mag_pin_reg       <= 1'b0;
        end
        else
        begin
            off_count_reg     <= off_count_next;
            firing_reg        <= firing_next;
            timer_reg         <= timer_next;
            fault_reg         <= fault_next;
            shot_reg          <= shot_next;
            mag_remaining_reg <= mag_remaining_next;
            last_inhibit_reg  <= last_inhibit_next;
            mag_pin_reg       <= mag_pin_next;
        end
    end

endmodule
